FILE: rtl/pbu_pkg.sv
// Package for the POMDP belief update and sampler.
// Holds the request opcodes, status codes, register indexes and controller states.
// No dependencies.
package pbu_pkg;

  localparam int PROB_W = 16;
  localparam int QUOT_W = 17;

  typedef enum logic [2:0] {
    OP_LOAD_T    = 3'd0,
    OP_LOAD_O    = 3'd1,
    OP_INIT      = 3'd2,
    OP_UPDATE    = 3'd3,
    OP_READ      = 3'd4,
    OP_SAMPLE_S  = 3'd5,
    OP_SAMPLE_O  = 3'd6,
    OP_SET_TERM  = 3'd7
  } pbu_op_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_NORM = 2'd1;
  localparam logic [1:0] STAT_NO_SAMPLE = 2'd2;

  localparam logic CFG_STATES = 1'b0;
  localparam logic CFG_OBS    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_IDIV,
    ST_UT,
    ST_UD1,
    ST_UD2,
    ST_UD3,
    ST_UW,
    ST_UCHK,
    ST_NRD,
    ST_NLD,
    ST_NDIV,
    ST_SRD,
    ST_SACC,
    ST_SCMP,
    ST_FIN
  } pbu_state_t;

endpackage

FILE: rtl/pbu_div.sv
// Restoring divider producing a 17-bit quotient, one bit per cycle.
// Shared by the uniform belief init and the belief normalization.
// Depends on pbu_pkg.
module pbu_div #(
  parameter int NW = 53,
  parameter int DW = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [pbu_pkg::QUOT_W-1:0] quotient
);
  import pbu_pkg::*;

  localparam int CW = $clog2(QUOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     div_r;
  logic [QUOT_W-1:0] lo_r;
  logic [QUOT_W-1:0] q_r;
  logic [DW:0]       trial;
  logic              ge;

  assign trial = {rem_r, lo_r[QUOT_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(dividend[NW-1:QUOT_W]);
      lo_r  <= dividend[QUOT_W-1:0];
      div_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, div_r}) : DW'(trial);
      lo_r  <= {lo_r[QUOT_W-2:0], 1'b0};
      q_r   <= {q_r[QUOT_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/pomdp_belief_update_sampler_top.sv
// Top level of the POMDP belief update and sampler.
// Holds the transition, observation and partial-weight memories and the controller.
// Depends on pbu_pkg and pbu_div.
//
// Usage: requests arrive on the in_ channel (valid/ready) and each produces exactly
// one result on the out_ channel (valid/ready). One request is worked on at a time;
// in_ready is high while the controller is idle, even if a result still waits.
// Init makes one pass of the shared 17-step divider. Sampling reads up to a row
// of n entries, one synchronous table read per entry. An update for S states in
// use makes the S*S transition reads through the table port, one per cycle within
// each row, then, unless the weights sum to zero, normalizes each entry through
// the shared divider. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce. Reset (synchronous, active low) clears
// the belief vector and terminal marks, sets both counts to 16 and empties the
// output register; table contents are undefined until loaded. When the receiver
// stalls, the result is held in the output register; a new request can still be
// taken, but its result waits in the controller until the held one is taken.
module pomdp_belief_update_sampler_top #(
  parameter int MAX_STATES       = 16,
  parameter int MAX_OBSERVATIONS = 16,
  parameter int MAX_ACTIONS      = 4,
  parameter int DRAW_BASE        = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_from_state,
  input  logic [3:0]  in_target_index,
  input  logic [15:0] in_prob_value,
  input  logic [9:0]  in_random_draw,
  input  logic        in_terminal_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_sampled_index,
  output logic [15:0] out_belief_value,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import pbu_pkg::*;

  localparam int MAXN   = (MAX_STATES > MAX_OBSERVATIONS) ? MAX_STATES : MAX_OBSERVATIONS;
  localparam int XW     = $clog2(MAXN);
  localparam int BW     = $clog2(MAX_STATES);
  localparam int SCW    = $clog2(MAX_STATES + 1);
  localparam int OCW    = $clog2(MAX_OBSERVATIONS + 1);
  localparam int TDEPTH = MAX_ACTIONS * MAX_STATES * MAX_STATES;
  localparam int ODEPTH = MAX_ACTIONS * MAX_STATES * MAX_OBSERVATIONS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int OAW    = $clog2(ODEPTH);
  localparam int TSW    = 2 * PROB_W + $clog2(MAX_STATES);
  localparam int WW     = TSW;
  localparam int AW     = WW + $clog2(MAX_STATES);
  localparam int NW     = WW + QUOT_W;
  localparam int CW     = PROB_W + $clog2(MAXN) + 1;
  localparam int PW     = CW + 17;

  function automatic logic [TAW-1:0] t_addr(input int a, input int f, input int t);
    return TAW'(a * MAX_STATES * MAX_STATES + f * MAX_STATES + t);
  endfunction

  function automatic logic [OAW-1:0] o_addr(input int a, input int s, input int o);
    return OAW'(a * MAX_STATES * MAX_OBSERVATIONS + s * MAX_OBSERVATIONS + o);
  endfunction

  pbu_state_t state_r, state_nxt;

  logic [4:0]  cfg_states_r, cfg_obs_r;
  logic [SCW-1:0] eff_s, den;
  logic [OCW-1:0] eff_o;

  logic [2:0]  op_r;
  logic [1:0]  act_r;
  logic [3:0]  from_r, tgt_r;
  logic [15:0] prob_r;
  logic [9:0]  draw_r;
  logic        tflag_r;

  logic [XW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] jdx_r, jdx_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [WW-1:0] wprod_r, wprod_nxt;
  logic [3:0]  res_idx_r, res_idx_nxt;
  logic [15:0] res_bel_r, res_bel_nxt;
  logic [1:0]  res_st_r, res_st_nxt;

  logic        out_valid_r;
  logic [3:0]  out_idx_r;
  logic [15:0] out_bel_r;
  logic [1:0]  out_st_r;

  logic [15:0] belief_r [MAX_STATES];
  logic        term_r [MAX_STATES];

  logic [15:0] t_mem [TDEPTH];
  logic [15:0] o_mem [ODEPTH];
  logic [WW-1:0] w_mem [MAX_STATES];
  logic [15:0] t_q_r, o_q_r;
  logic [WW-1:0] w_q_r;

  logic          rd_v_r, mul_v_r;
  logic [BW-1:0] rd_j_r;
  logic [31:0]   prod_r;
  logic [TSW-1:0] tsum_r;

  logic t_re, t_we, o_re, o_we, w_re, w_we, tsum_clr;
  logic [TAW-1:0] t_raddr, t_waddr;
  logic [OAW-1:0] o_raddr, o_waddr;
  logic bel_init, bel_wr_one, term_we, out_load;
  logic [15:0] bel_wdata;

  logic              div_start, div_done;
  logic [NW-1:0]     div_dividend;
  logic [AW-1:0]     div_divisor;
  logic [QUOT_W-1:0] div_q;
  logic [15:0]       q_sat;
  logic [PW-1:0]     c_scaled, draw_lim;
  logic              is_obs;

  pbu_div #(.NW(NW), .DW(AW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (cfg_states_r < 5'd2) begin
      eff_s = SCW'(2);
    end else if (int'(cfg_states_r) > MAX_STATES) begin
      eff_s = SCW'(MAX_STATES);
    end else begin
      eff_s = SCW'(cfg_states_r);
    end
    if (cfg_obs_r < 5'd1) begin
      eff_o = OCW'(1);
    end else if (int'(cfg_obs_r) > MAX_OBSERVATIONS) begin
      eff_o = OCW'(MAX_OBSERVATIONS);
    end else begin
      eff_o = OCW'(cfg_obs_r);
    end
  end

  assign den      = eff_s - SCW'(1);
  assign q_sat    = div_q[QUOT_W-1] ? 16'hFFFF : div_q[15:0];
  assign c_scaled = PW'(c_r) * PW'(DRAW_BASE);
  assign draw_lim = PW'({draw_r, 16'h0000});
  assign is_obs   = (pbu_op_t'(op_r) == OP_SAMPLE_O);
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_states_r <= 5'd16;
      cfg_obs_r    <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == CFG_STATES) begin
        cfg_states_r <= cfg_wdata;
      end else begin
        cfg_obs_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_opcode;
      act_r   <= in_action;
      from_r  <= in_from_state;
      tgt_r   <= in_target_index;
      prob_r  <= in_prob_value;
      draw_r  <= in_random_draw;
      tflag_r <= in_terminal_flag;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    jdx_nxt      = jdx_r;
    acc_nxt      = acc_r;
    c_nxt        = c_r;
    wprod_nxt    = wprod_r;
    res_idx_nxt  = res_idx_r;
    res_bel_nxt  = res_bel_r;
    res_st_nxt   = res_st_r;
    t_re         = 1'b0;
    t_we         = 1'b0;
    o_re         = 1'b0;
    o_we         = 1'b0;
    w_re         = 1'b0;
    w_we         = 1'b0;
    t_raddr      = '0;
    o_raddr      = '0;
    t_waddr      = t_addr(int'(act_r), int'(from_r), int'(tgt_r));
    o_waddr      = o_addr(int'(act_r), int'(from_r), int'(tgt_r));
    tsum_clr     = 1'b0;
    div_start    = 1'b0;
    div_dividend = NW'(17'h10000) + NW'(den >> 1);
    div_divisor  = AW'(den);
    bel_init     = 1'b0;
    bel_wr_one   = 1'b0;
    bel_wdata    = q_sat;
    term_we      = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_idx_nxt = '0;
          res_bel_nxt = '0;
          res_st_nxt  = STAT_OK;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
        case (pbu_op_t'(op_r))
          OP_LOAD_T: begin
            t_we = (int'(act_r) < MAX_ACTIONS) && (int'(from_r) < MAX_STATES) &&
                   (int'(tgt_r) < MAX_STATES);
          end
          OP_LOAD_O: begin
            o_we = (int'(act_r) < MAX_ACTIONS) && (int'(from_r) < MAX_STATES) &&
                   (int'(tgt_r) < MAX_OBSERVATIONS);
          end
          OP_INIT: begin
            div_start = 1'b1;
            state_nxt = ST_IDIV;
          end
          OP_UPDATE: begin
            if ((int'(act_r) >= MAX_ACTIONS) || (int'(tgt_r) >= int'(eff_o))) begin
              res_st_nxt = STAT_ZERO_NORM;
            end else begin
              idx_nxt   = '0;
              jdx_nxt   = '0;
              acc_nxt   = '0;
              tsum_clr  = 1'b1;
              state_nxt = ST_UT;
            end
          end
          OP_READ: begin
            if (int'(tgt_r) < MAX_STATES) begin
              res_bel_nxt = belief_r[BW'(tgt_r)];
            end
          end
          OP_SAMPLE_S, OP_SAMPLE_O: begin
            if ((int'(act_r) >= MAX_ACTIONS) || (int'(from_r) >= int'(eff_s))) begin
              res_st_nxt = STAT_NO_SAMPLE;
            end else begin
              idx_nxt   = '0;
              c_nxt     = '0;
              state_nxt = ST_SRD;
            end
          end
          OP_SET_TERM: begin
            term_we = (int'(from_r) < MAX_STATES);
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_IDIV: begin
        if (div_done) begin
          bel_init    = 1'b1;
          res_bel_nxt = q_sat;
          state_nxt   = ST_FIN;
        end
      end
      ST_UT: begin
        t_re    = 1'b1;
        t_raddr = t_addr(int'(act_r), int'(jdx_r), int'(idx_r));
        if (int'(jdx_r) == int'(eff_s) - 1) begin
          jdx_nxt   = '0;
          state_nxt = ST_UD1;
        end else begin
          jdx_nxt = jdx_r + BW'(1);
        end
      end
      ST_UD1: begin
        o_re      = 1'b1;
        o_raddr   = o_addr(int'(act_r), int'(idx_r), int'(tgt_r));
        state_nxt = ST_UD2;
      end
      ST_UD2: begin
        state_nxt = ST_UD3;
      end
      ST_UD3: begin
        wprod_nxt = WW'(o_q_r * tsum_r[TSW-1:PROB_W]);
        state_nxt = ST_UW;
      end
      ST_UW: begin
        w_we     = 1'b1;
        acc_nxt  = acc_r + AW'(wprod_r);
        tsum_clr = 1'b1;
        if (int'(idx_r) == int'(eff_s) - 1) begin
          idx_nxt   = '0;
          state_nxt = ST_UCHK;
        end else begin
          idx_nxt   = idx_r + XW'(1);
          state_nxt = ST_UT;
        end
      end
      ST_UCHK: begin
        if (acc_r == '0) begin
          res_st_nxt = STAT_ZERO_NORM;
          state_nxt  = ST_FIN;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_NRD;
        end
      end
      ST_NRD: begin
        w_re      = 1'b1;
        state_nxt = ST_NLD;
      end
      ST_NLD: begin
        div_start    = 1'b1;
        div_dividend = NW'({w_q_r, 16'h0000}) + NW'(acc_r >> 1);
        div_divisor  = acc_r;
        state_nxt    = ST_NDIV;
      end
      ST_NDIV: begin
        if (div_done) begin
          bel_wr_one = 1'b1;
          if (int'(idx_r) == int'(eff_s) - 1) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r + XW'(1);
            state_nxt = ST_NRD;
          end
        end
      end
      ST_SRD: begin
        if (is_obs) begin
          o_re    = 1'b1;
          o_raddr = o_addr(int'(act_r), int'(from_r), int'(idx_r));
        end else begin
          t_re    = 1'b1;
          t_raddr = t_addr(int'(act_r), int'(from_r), int'(idx_r));
        end
        state_nxt = ST_SACC;
      end
      ST_SACC: begin
        c_nxt     = c_r + CW'(is_obs ? o_q_r : t_q_r);
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if (c_scaled > draw_lim) begin
          res_idx_nxt = 4'(idx_r);
          state_nxt   = ST_FIN;
        end else if (int'(idx_r) == (is_obs ? int'(eff_o) : int'(eff_s)) - 1) begin
          res_st_nxt = STAT_NO_SAMPLE;
          state_nxt  = ST_FIN;
        end else begin
          idx_nxt   = idx_r + XW'(1);
          state_nxt = ST_SRD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= t_re && (state_r == ST_UT);
      mul_v_r <= rd_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    jdx_r     <= jdx_nxt;
    acc_r     <= acc_nxt;
    c_r       <= c_nxt;
    wprod_r   <= wprod_nxt;
    res_idx_r <= res_idx_nxt;
    res_bel_r <= res_bel_nxt;
    res_st_r  <= res_st_nxt;
    rd_j_r    <= jdx_r;
    prod_r    <= belief_r[rd_j_r] * t_q_r;
    if (tsum_clr) begin
      tsum_r <= '0;
    end else if (mul_v_r) begin
      tsum_r <= tsum_r + TSW'(prod_r);
    end
    if (out_load) begin
      out_idx_r <= res_idx_r;
      out_bel_r <= res_bel_r;
      out_st_r  <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      t_mem[t_waddr] <= prob_r;
    end
    if (t_re) begin
      t_q_r <= t_mem[t_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      o_mem[o_waddr] <= prob_r;
    end
    if (o_re) begin
      o_q_r <= o_mem[o_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[idx_r[BW-1:0]] <= wprod_r;
    end
    if (w_re) begin
      w_q_r <= w_mem[idx_r[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        belief_r[i] <= '0;
        term_r[i]   <= 1'b0;
      end
    end else begin
      if (bel_init) begin
        for (int i = 0; i < MAX_STATES; i++) begin
          belief_r[i] <= ((i < int'(eff_s)) && !term_r[i]) ? bel_wdata : 16'h0000;
        end
      end else if (bel_wr_one) begin
        belief_r[idx_r[BW-1:0]] <= bel_wdata;
      end
      if (term_we) begin
        term_r[BW'(from_r)] <= tflag_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sampled_index = out_idx_r;
  assign out_belief_value  = out_bel_r;
  assign out_status        = out_st_r;

endmodule

FILE: rtl/pbu_checker.sv
// Port-level assertions for the POMDP belief update and sampler.
// Attached to pomdp_belief_update_sampler_top by the bind at the end of this file.
// Depends on pbu_pkg.
module pbu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_sampled_index,
  input logic [15:0] out_belief_value,
  input logic [1:0]  out_status
);
  import pbu_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in progress");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_belief_value) && $stable(out_sampled_index))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_OK || out_status == STAT_ZERO_NORM ||
    out_status == STAT_NO_SAMPLE)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_sampled_index == 4'd0 &&
    out_belief_value == 16'd0)
    else $error("failed request carries data");

endmodule

bind pomdp_belief_update_sampler_top pbu_checker u_pbu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sampled_index (out_sampled_index),
  .out_belief_value  (out_belief_value),
  .out_status        (out_status)
);
